>>> rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types for the fixed-point ALU
// Command codes and the control word that travels down the cell chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // Command codes carried in s_tuser.
    typedef enum logic [3:0] {
        CMD_ADD    = 4'd0,
        CMD_SUB    = 4'd1,
        CMD_MUL    = 4'd2,
        CMD_DIV    = 4'd3,
        CMD_GT     = 4'd4,
        CMD_LT     = 4'd5,
        CMD_GE     = 4'd6,
        CMD_LE     = 4'd7,
        CMD_EQ     = 4'd8,
        CMD_NE     = 4'd9,
        CMD_INC    = 4'd10,
        CMD_DEC    = 4'd11,
        CMD_MIN    = 4'd12,
        CMD_MAX    = 4'd13,
        CMD_TO_INT = 4'd14
    } cmd_t;

    // Per-transaction control word handed from cell to cell.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic sneg;
        logic dbz;
        logic cmp;
    } ctl_t;

endpackage

>>> rtl/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell: one step of the multiply and divide chain
// Performs one restoring divide step and, for IDX below W, one shift-add multiply step.
// ----------------------------------------------------------------------------
module fpa_cell #(
    parameter int W   = 32,
    parameter int F   = 8,
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  fpa_pkg::ctl_t     ctl_in,
    input  logic [W-1:0]      simple_in,
    input  logic [W-1:0]      x_in,
    input  logic [W-1:0]      y_in,
    input  logic [W+F-1:0]    acc_in,
    input  logic [W-1:0]      rem_in,
    input  logic [W+F-1:0]    dq_in,
    output fpa_pkg::ctl_t     ctl_out,
    output logic [W-1:0]      simple_out,
    output logic [W-1:0]      x_out,
    output logic [W-1:0]      y_out,
    output logic [W+F-1:0]    acc_out,
    output logic [W-1:0]      rem_out,
    output logic [W+F-1:0]    dq_out
);

    localparam int N = W + F;

    logic              valid_reg;
    fpa_pkg::ctl_t     ctl_reg;
    logic [W-1:0]      simple_reg, x_reg, y_reg, rem_reg;
    logic [N-1:0]      acc_reg, dq_reg;
    logic [N-1:0]      acc_next, dq_next;
    logic [W-1:0]      rem_next;
    logic [W:0]        trial;
    logic [N-1:0]      addend;

    // Multiply step: add the shifted multiplicand when this bit of y is set.
    always_comb begin
        addend   = {{F{1'b0}}, x_in} << IDX;
        acc_next = acc_in;
        if (IDX < W) begin
            if (y_in[IDX % W]) begin
                acc_next = acc_in + addend;
            end
        end
    end

    // Divide step: bring down one dividend bit and try to subtract y.
    always_comb begin
        trial = {rem_in, dq_in[N-1]};
        if (trial >= {1'b0, y_in}) begin
            rem_next = W'(trial - {1'b0, y_in});
            dq_next  = {dq_in[N-2:0], 1'b1};
        end else begin
            rem_next = trial[W-1:0];
            dq_next  = {dq_in[N-2:0], 1'b0};
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= ctl_in.valid;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg    <= ctl_in;
            simple_reg <= simple_in;
            x_reg      <= x_in;
            y_reg      <= y_in;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            dq_reg     <= dq_next;
        end
    end

    always_comb begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign simple_out = simple_reg;
    assign x_out      = x_reg;
    assign y_out      = y_reg;
    assign acc_out    = acc_reg;
    assign rem_out    = rem_reg;
    assign dq_out     = dq_reg;

endmodule

>>> rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: signed fixed-point ALU with a pipelined cell chain
// A transaction passes through the chain of one restoring-divide cell per
// dividend bit and then through the output register. Throughput: one
// transaction per cycle; the chain stalls only while the output register is
// held. Reset (aresetn low, synchronous) empties the chain and the output
// register.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*WORD_WIDTH-1:0] s_tdata,   // operand_b (upper), operand_a (lower)
    input  logic [3:0]              s_tuser,   // command
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [WORD_WIDTH-1:0]   m_tdata,   // result_value
    output logic [1:0]              m_tuser    // divide_by_zero, compare_true
);

    localparam int W = WORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int N = W + F;

    logic adv;

    fpa_pkg::ctl_t ctl    [0:N];
    logic [W-1:0]  simple [0:N];
    logic [W-1:0]  xs     [0:N];
    logic [W-1:0]  ys     [0:N];
    logic [N-1:0]  acc    [0:N];
    logic [W-1:0]  rem    [0:N];
    logic [N-1:0]  dq     [0:N];

    logic [W-1:0] a, b, mag_a, mag_b, int_mag;
    logic         lt_ab, lt_ba;

    // Entry decode: simple operations and operand magnitudes.
    always_comb begin
        a      = s_tdata[W-1:0];
        b      = s_tdata[2*W-1:W];
        lt_ab  = $signed(a) < $signed(b);
        lt_ba  = $signed(b) < $signed(a);
        mag_a  = a[W-1] ? W'(-a) : a;
        mag_b  = b[W-1] ? W'(-b) : b;
        int_mag = mag_a >> F;
        ctl[0].valid = s_tvalid;
        ctl[0].cmd   = fpa_pkg::cmd_t'(s_tuser);
        ctl[0].sneg  = a[W-1] ^ b[W-1];
        ctl[0].dbz   = 1'b0;
        ctl[0].cmp   = 1'b0;
        simple[0]    = '0;
        case (fpa_pkg::cmd_t'(s_tuser))
            fpa_pkg::CMD_ADD:    simple[0] = a + b;
            fpa_pkg::CMD_SUB:    simple[0] = a - b;
            fpa_pkg::CMD_DIV:    ctl[0].dbz = (b == '0);
            fpa_pkg::CMD_GT:     ctl[0].cmp = lt_ba;
            fpa_pkg::CMD_LT:     ctl[0].cmp = lt_ab;
            fpa_pkg::CMD_GE:     ctl[0].cmp = !lt_ab;
            fpa_pkg::CMD_LE:     ctl[0].cmp = !lt_ba;
            fpa_pkg::CMD_EQ:     ctl[0].cmp = (a == b);
            fpa_pkg::CMD_NE:     ctl[0].cmp = (a != b);
            fpa_pkg::CMD_INC:    simple[0] = a + W'(1);
            fpa_pkg::CMD_DEC:    simple[0] = a - W'(1);
            fpa_pkg::CMD_MIN:    simple[0] = lt_ba ? b : a;
            fpa_pkg::CMD_MAX:    simple[0] = lt_ab ? b : a;
            fpa_pkg::CMD_TO_INT: simple[0] = a[W-1] ? W'(-int_mag) : int_mag;
            default:             simple[0] = '0;
        endcase
        xs[0]  = mag_a;
        ys[0]  = mag_b;
        acc[0] = '0;
        rem[0] = '0;
        dq[0]  = {mag_a, {F{1'b0}}};
    end

    // Chain of cells, one divide step each (and a multiply step in the first W).
    for (genvar i = 0; i < N; i++) begin : g_cell
        fpa_cell #(.W(W), .F(F), .IDX(i)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .ctl_in     (ctl[i]),
            .simple_in  (simple[i]),
            .x_in       (xs[i]),
            .y_in       (ys[i]),
            .acc_in     (acc[i]),
            .rem_in     (rem[i]),
            .dq_in      (dq[i]),
            .ctl_out    (ctl[i+1]),
            .simple_out (simple[i+1]),
            .x_out      (xs[i+1]),
            .y_out      (ys[i+1]),
            .acc_out    (acc[i+1]),
            .rem_out    (rem[i+1]),
            .dq_out     (dq[i+1])
        );
    end

    logic          m_tvalid_reg;
    logic [W-1:0]  m_tdata_reg, m_tdata_next, mul_mag, div_mag, mag_sel;
    logic [1:0]    m_tuser_reg;
    logic [N-1:0]  mul_sum;
    logic          round_up;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Final rounding, sign and result selection.
    always_comb begin
        mul_sum  = acc[N] + (N'(1) << (F - 1));
        mul_mag  = mul_sum[N-1:F];
        round_up = rem[N] >= W'(ys[N] - rem[N]);
        div_mag  = dq[N][W-1:0] + W'(round_up);
        mag_sel  = (ctl[N].cmd == fpa_pkg::CMD_MUL) ? mul_mag : div_mag;
        if (ctl[N].cmd == fpa_pkg::CMD_MUL || ctl[N].cmd == fpa_pkg::CMD_DIV) begin
            m_tdata_next = ctl[N].sneg ? W'(-mag_sel) : mag_sel;
        end else begin
            m_tdata_next = simple[N];
        end
        if (ctl[N].dbz) begin
            m_tdata_next = '0;
        end
        for (int k = 32; k < W; k++) begin
            m_tdata_next[k] = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= ctl[N].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= {ctl[N].dbz, ctl[N].cmp};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A divide-by-zero transaction returns a zero result.
    a_dbz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("divide by zero with non-zero result");

    // Comparisons never report a value.
    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("compare result carries value or error flag");

    // A stalled output must not be lost while the chain is held.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("chain advanced while output was stalled");

endmodule
